// File: rtl/core/qtl_pkg.sv
// Shared types, character codes and the per-byte transition function of the query text lexer.
`default_nettype none
package qtl_pkg;

	localparam int unsigned QTL_FIFO_DEPTH = 4;

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;

	localparam logic [1:0] KIND_LIT   = 2'd0;
	localparam logic [1:0] KIND_WORD  = 2'd1;
	localparam logic [1:0] KIND_CMP   = 2'd2;
	localparam logic [1:0] KIND_PUNCT = 2'd3;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_LIT  = 2'd2,
		MODE_PEND = 2'd3
	} qtl_mode_t;

	typedef struct packed {
		qtl_mode_t  mode;
		logic [7:0] held_byte;
		logic       held_valid;
		logic       held_starts;
		logic       literal_empty;
	} lex_state_t;

	typedef struct packed {
		logic [7:0] tok_byte;
		logic       tok_first;
		logic       tok_last;
		logic       tok_empty;
		logic [1:0] tok_kind;
		logic       run_end;
	} tok_t;

	typedef struct packed {
		tok_t       r0;
		tok_t       r1;
		logic [1:0] n;
	} tok_pair_t;

	typedef struct packed {
		lex_state_t nxt;
		tok_pair_t  res;
	} step_t;

	function automatic logic char_is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic char_is_word(logic [7:0] c);
		return char_is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
			((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_UNDER) || (c == CH_DOT);
	endfunction

	function automatic tok_t mk_tok(logic [7:0] b, logic f, logic l, logic e, logic [1:0] k);
		tok_t t;
		t.tok_byte  = b;
		t.tok_first = f;
		t.tok_last  = l;
		t.tok_empty = e;
		t.tok_kind  = k;
		t.run_end   = 1'b0;
		return t;
	endfunction

	function automatic tok_pair_t push_tok(tok_pair_t p, tok_t t);
		tok_pair_t q;
		q = p;
		if (p.n == 2'd0) begin
			q.r0 = t;
			q.n  = 2'd1;
		end else if (p.n == 2'd1) begin
			q.r1 = t;
			q.n  = 2'd2;
		end
		return q;
	endfunction

	function automatic lex_state_t idle_state();
		lex_state_t s;
		s.mode          = MODE_IDLE;
		s.held_byte     = 8'h00;
		s.held_valid    = 1'b0;
		s.held_starts   = 1'b0;
		s.literal_empty = 1'b0;
		return s;
	endfunction

	function automatic lex_state_t hold_state(lex_state_t s, qtl_mode_t m, logic [7:0] b,
			logic starts);
		lex_state_t q;
		q             = s;
		q.mode        = m;
		q.held_byte   = b;
		q.held_valid  = 1'b1;
		q.held_starts = starts;
		return q;
	endfunction

	function automatic step_t qtl_step(lex_state_t st, logic [7:0] c, logic last);
		step_t      r;
		lex_state_t s;
		logic [7:0] h;
		logic       used;
		logic       starts;
		r       = '0;
		s       = st;
		h       = st.held_byte;
		used    = 1'b0;
		starts  = 1'b0;
		unique case (st.mode)
			MODE_WORD: begin
				if (char_is_word(c)) begin
					r.res = push_tok(r.res, mk_tok(h, st.held_starts, 1'b0, 1'b0, KIND_WORD));
					s     = hold_state(s, MODE_WORD, c, 1'b0);
					used  = 1'b1;
				end else begin
					r.res = push_tok(r.res, mk_tok(h, st.held_starts, 1'b1, 1'b0, KIND_WORD));
					s     = idle_state();
				end
			end
			MODE_LIT: begin
				if (c == CH_QUOTE) begin
					if (st.literal_empty || !st.held_valid)
						r.res = push_tok(r.res, mk_tok(8'h00, 1'b1, 1'b1, 1'b1, KIND_LIT));
					else
						r.res = push_tok(r.res, mk_tok(h, st.held_starts, 1'b1, 1'b0, KIND_LIT));
					s = idle_state();
				end else begin
					starts = st.literal_empty;
					if (st.held_valid)
						r.res = push_tok(r.res, mk_tok(h, st.held_starts, 1'b0, 1'b0, KIND_LIT));
					s               = hold_state(s, MODE_LIT, c, starts);
					s.literal_empty = 1'b0;
				end
				used = 1'b1;
			end
			MODE_PEND: begin
				priority if ((h != CH_MINUS) && (c == CH_EQ)) begin
					r.res = push_tok(r.res, mk_tok(h, 1'b1, 1'b0, 1'b0, KIND_CMP));
					r.res = push_tok(r.res, mk_tok(c, 1'b0, 1'b1, 1'b0, KIND_CMP));
					s     = idle_state();
					used  = 1'b1;
				end else if ((h == CH_MINUS) && char_is_digit(c)) begin
					r.res = push_tok(r.res, mk_tok(h, 1'b1, 1'b0, 1'b0, KIND_WORD));
					s     = hold_state(s, MODE_WORD, c, 1'b0);
					used  = 1'b1;
				end else begin
					if ((h == CH_LT) || (h == CH_GT))
						r.res = push_tok(r.res, mk_tok(h, 1'b1, 1'b1, 1'b0, KIND_CMP));
					s = idle_state();
				end
			end
			MODE_IDLE: begin
			end
		endcase

		if (!used) begin
			priority if (c == CH_QUOTE) begin
				s               = idle_state();
				s.mode          = MODE_LIT;
				s.literal_empty = 1'b1;
			end else if ((c == CH_GT) || (c == CH_LT) || (c == CH_BANG) || (c == CH_MINUS)) begin
				s = hold_state(s, MODE_PEND, c, 1'b1);
			end else if (c == CH_EQ) begin
				r.res = push_tok(r.res, mk_tok(c, 1'b1, 1'b1, 1'b0, KIND_CMP));
			end else if ((c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA) ||
					(c == CH_STAR)) begin
				r.res = push_tok(r.res, mk_tok(c, 1'b1, 1'b1, 1'b0, KIND_PUNCT));
			end else if (char_is_word(c)) begin
				s = hold_state(s, MODE_WORD, c, 1'b1);
			end else begin
			end
		end

		if (last) begin
			unique case (s.mode)
				MODE_WORD: begin
					r.res = push_tok(r.res,
						mk_tok(s.held_byte, s.held_starts, 1'b1, 1'b0, KIND_WORD));
				end
				MODE_LIT: begin
					if (s.literal_empty || !s.held_valid)
						r.res = push_tok(r.res, mk_tok(8'h00, 1'b1, 1'b1, 1'b1, KIND_LIT));
					else
						r.res = push_tok(r.res,
							mk_tok(s.held_byte, s.held_starts, 1'b1, 1'b0, KIND_LIT));
				end
				MODE_PEND: begin
					if ((s.held_byte == CH_LT) || (s.held_byte == CH_GT))
						r.res = push_tok(r.res,
							mk_tok(s.held_byte, 1'b1, 1'b1, 1'b0, KIND_CMP));
				end
				MODE_IDLE: begin
				end
			endcase
			s = idle_state();
		end

		if (r.res.n == 2'd1)
			r.res.r0.run_end = 1'b1;
		else if (r.res.n == 2'd2)
			r.res.r1.run_end = 1'b1;

		r.nxt = s;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/query_text_lexer_core.sv
// Query text lexer: one text byte in per transfer, token bytes out through a small result queue.
//
// Usage:
//   Input channel s_*: one query text byte per transfer in s_tdata, s_tlast set on the
//   final byte of the text. Output channel m_*: one token byte per transfer; m_tdata
//   carries the byte with first, last and empty marks, m_tuser the token kind, and
//   m_tlast marks the last result caused by one input byte.
//   A byte is held in the input register; its results are written into the result queue
//   and offered from there.
//   The lexer holds one byte back as lookahead, so a token byte normally appears when
//   the following byte arrives; s_tlast flushes the held byte.
//   Throughput: one byte per cycle while the receiver keeps up and each byte causes at
//   most one result. A byte causes two results for a two-character comparison, when it
//   ends a held token and is itself a one-byte token, or at a flush; the result queue
//   (FIFO_DEPTH entries) absorbs these. s_tready is set while the queue, after the results
//   of the byte in the input register, has room for one more byte with up to two results.
//   Reset clears the lexer to idle, empties the queue and the input register.
//   When the receiver stalls, results collect in the queue; once it is nearly full
//   s_tready drops and no text byte is lost.
`default_nettype none
module query_text_lexer_core
	import qtl_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = QTL_FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] ch
	input  wire logic        s_tlast,   // last_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] tok_byte, [8] tok_first, [9] tok_last,
	                                    // [10] tok_empty, [15:11] zero
	output logic [1:0]       m_tuser,   // [1:0] tok_kind
	output logic             m_tlast    // run_end
);

	localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W:0]   ROOM_LIM = (CNT_W + 1)'(FIFO_DEPTH - 2);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;

	lex_state_t       state_q;
	lex_state_t       state_next;
	tok_pair_t        res;
	step_t            step_nxt;
	step_t            step_out;

	tok_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_p1;
	logic [PTR_W-1:0] wr_ptr_p2;
	logic [PTR_W-1:0] rd_ptr_p1;
	logic [1:0]       push_n;
	logic             pop;
	logic [CNT_W:0]   fill_sum;
	tok_t             head;

	always_comb begin
		step_nxt   = qtl_step(state_q, ch_s1, last_s1);
		state_next = valid_s1 ? step_nxt.nxt : state_q;
	end

	always_comb begin
		step_out = qtl_step(state_q, ch_s1, last_s1);
		res      = step_out.res;
		push_n   = valid_s1 ? res.n : 2'd0;
	end

	assign wr_ptr_p1 = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
	assign wr_ptr_p2 = (wr_ptr_p1 == LAST_PTR) ? '0 : wr_ptr_p1 + 1'b1;
	assign rd_ptr_p1 = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
	assign pop       = m_tvalid && m_tready;
	assign fill_sum  = {1'b0, count_q} + (CNT_W + 1)'(push_n);
	assign s_tready  = (fill_sum <= ROOM_LIM);

	assign head      = fifo_q[rd_ptr_q];
	assign m_tvalid  = (count_q != '0);
	assign m_tdata   = {5'b0, head.tok_empty, head.tok_last, head.tok_first, head.tok_byte};
	assign m_tuser   = head.tok_kind;
	assign m_tlast   = head.run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end else begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idle_state();
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			fifo_q[wr_ptr_q] <= res.r0;
		if (push_n == 2'd2)
			fifo_q[wr_ptr_p1] <= res.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (push_n)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= wr_ptr_p2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop)
				rd_ptr_q <= rd_ptr_p1;
			count_q <= CNT_W'(fill_sum - (CNT_W + 1)'(pop));
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (fill_sum <= (CNT_W + 1)'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (state_q.mode == MODE_IDLE) && !state_q.held_valid)
		else $error("lexer not idle after final byte");

	a_run_end_once: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (res.r1.run_end && !res.r0.run_end))
		else $error("run end mark misplaced on double result");

	a_run_end_single: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd1) |-> res.r0.run_end)
		else $error("run end mark missing on single result");

	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (push_n == 2'd0)) |=> (count_q == CNT_W'($past(count_q) - 1'b1)))
		else $error("queue count did not follow a transfer");

endmodule
`default_nettype wire

// File: verif/query_text_lexer_checker.sv
// Token stream checker for the query text lexer: predicts token transfers and compares them.
`default_nettype none
module query_text_lexer_checker
	import qtl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        s_tlast,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	input  wire logic        m_tlast,
	output int               mismatches,
	output int               outstanding
);

	typedef struct packed {
		logic [7:0] tok_byte;
		logic       tok_first;
		logic       tok_last;
		logic       tok_empty;
		logic [1:0] tok_kind;
		logic       run_end;
	} token_t;

	qtl_mode_t  mode;
	logic [7:0] held;
	logic       held_valid;
	logic       held_starts;
	logic       lit_empty;

	token_t token_queue[$];
	token_t step_toks[$];

	function automatic logic digit_char(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic word_char(logic [7:0] c);
		return digit_char(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
			(c == CH_UNDER) || (c == CH_DOT);
	endfunction

	task emit(input logic [7:0] b, input logic f, input logic l, input logic e,
			input logic [1:0] k);
		token_t t;
		t.tok_byte  = b;
		t.tok_first = f;
		t.tok_last  = l;
		t.tok_empty = e;
		t.tok_kind  = k;
		t.run_end   = 1'b0;
		if (step_toks.size() < 2)
			step_toks = {step_toks, t};
	endtask

	task go_idle();
		mode        = MODE_IDLE;
		held        = 8'h00;
		held_valid  = 1'b0;
		held_starts = 1'b0;
		lit_empty   = 1'b0;
	endtask

	task keep(input qtl_mode_t m, input logic [7:0] b, input logic st);
		mode        = m;
		held        = b;
		held_valid  = 1'b1;
		held_starts = st;
	endtask

	task lex_byte(input logic [7:0] c, input logic fin);
		logic [7:0] h;
		logic       used;
		logic       st;
		h    = held;
		used = 1'b0;
		step_toks.delete();
		case (mode)
			MODE_WORD: begin
				if (word_char(c)) begin
					emit(h, held_starts, 1'b0, 1'b0, KIND_WORD);
					keep(MODE_WORD, c, 1'b0);
					used = 1'b1;
				end else begin
					emit(h, held_starts, 1'b1, 1'b0, KIND_WORD);
					go_idle();
				end
			end
			MODE_LIT: begin
				if (c == CH_QUOTE) begin
					if (lit_empty || !held_valid)
						emit(8'h00, 1'b1, 1'b1, 1'b1, KIND_LIT);
					else
						emit(h, held_starts, 1'b1, 1'b0, KIND_LIT);
					go_idle();
				end else begin
					st = lit_empty;
					if (held_valid)
						emit(h, held_starts, 1'b0, 1'b0, KIND_LIT);
					keep(MODE_LIT, c, st);
					lit_empty = 1'b0;
				end
				used = 1'b1;
			end
			MODE_PEND: begin
				if ((h != CH_MINUS) && (c == CH_EQ)) begin
					emit(h, 1'b1, 1'b0, 1'b0, KIND_CMP);
					emit(c, 1'b0, 1'b1, 1'b0, KIND_CMP);
					go_idle();
					used = 1'b1;
				end else if ((h == CH_MINUS) && digit_char(c)) begin
					emit(h, 1'b1, 1'b0, 1'b0, KIND_WORD);
					keep(MODE_WORD, c, 1'b0);
					used = 1'b1;
				end else begin
					if ((h == CH_LT) || (h == CH_GT))
						emit(h, 1'b1, 1'b1, 1'b0, KIND_CMP);
					go_idle();
				end
			end
			default: begin
			end
		endcase

		if (!used) begin
			if (c == CH_QUOTE) begin
				go_idle();
				mode      = MODE_LIT;
				lit_empty = 1'b1;
			end else if ((c == CH_GT) || (c == CH_LT) || (c == CH_BANG) || (c == CH_MINUS)) begin
				keep(MODE_PEND, c, 1'b1);
			end else if (c == CH_EQ) begin
				emit(c, 1'b1, 1'b1, 1'b0, KIND_CMP);
			end else if ((c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA) ||
					(c == CH_STAR)) begin
				emit(c, 1'b1, 1'b1, 1'b0, KIND_PUNCT);
			end else if (word_char(c)) begin
				keep(MODE_WORD, c, 1'b1);
			end
		end

		if (fin) begin
			case (mode)
				MODE_WORD: begin
					emit(held, held_starts, 1'b1, 1'b0, KIND_WORD);
				end
				MODE_LIT: begin
					if (lit_empty || !held_valid)
						emit(8'h00, 1'b1, 1'b1, 1'b1, KIND_LIT);
					else
						emit(held, held_starts, 1'b1, 1'b0, KIND_LIT);
				end
				MODE_PEND: begin
					if ((held == CH_LT) || (held == CH_GT))
						emit(held, 1'b1, 1'b1, 1'b0, KIND_CMP);
				end
				default: begin
				end
			endcase
			go_idle();
		end

		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].run_end = 1'b1;
		token_queue = {token_queue, step_toks};
	endtask

	task note_mismatch(input string what, input token_t want, input token_t got);
		mismatches = mismatches + 1;
		if (mismatches <= 10)
			$display("%s: expected byte %h first %b last %b empty %b kind %0d end %b, got byte %h first %b last %b empty %b kind %0d end %b",
				what, want.tok_byte, want.tok_first, want.tok_last, want.tok_empty,
				want.tok_kind, want.run_end, got.tok_byte, got.tok_first, got.tok_last,
				got.tok_empty, got.tok_kind, got.run_end);
	endtask

	initial begin
		mismatches  = 0;
		outstanding = 0;
		go_idle();
	end

	always @(posedge clk) begin : observe
		token_t got;
		token_t want;
		if (!arst_n) begin
			go_idle();
			token_queue.delete();
		end else begin
			if (s_tvalid && s_tready)
				lex_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got.tok_byte  = m_tdata[7:0];
				got.tok_first = m_tdata[8];
				got.tok_last  = m_tdata[9];
				got.tok_empty = m_tdata[10];
				got.tok_kind  = m_tuser;
				got.run_end   = m_tlast;
				if (token_queue.size() == 0) begin
					note_mismatch("unexpected token transfer", '0, got);
				end else begin
					want = token_queue.pop_front();
					if (got !== want || m_tdata[15:11] !== 5'd0)
						note_mismatch("token mismatch", want, got);
				end
			end
			outstanding = token_queue.size();
		end
	end

endmodule
`default_nettype wire

// File: verif/query_text_lexer_core_test.sv
// Testbench top for the query text lexer core: reset, text stimulus, receiver stalls, verdict.
`default_nettype none
module query_text_lexer_core_test;
	import qtl_pkg::*;

	localparam int TEXT_BYTES  = 1300;
	localparam int HOLD_OFF    = 300;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int mismatches;
	int outstanding;
	int cycles     = 0;
	int burst_left = 1;
	int sent       = 0;

	logic [7:0] query_bytes[$];

	always #5 clk = ~clk;

	query_text_lexer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	query_text_lexer_checker token_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[query_text_lexer_core] ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	task add_byte(input logic [7:0] c);
		query_bytes = {query_bytes, c};
	endtask

	task push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task send_byte(input logic [7:0] c, input logic fin);
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent       = sent + 1;
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	initial begin : receiver
		int phase_no;
		int style;
		int span;
		phase_no = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			phase_no = phase_no + 1;
			if (phase_no == 4) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				style = $urandom_range(0, 3);
				span  = $urandom_range(10, 120);
				for (int k = 0; k < span; k++) begin
					case (style)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= (k % 3 != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int frags;
		int choice;
		int len;
		logic [7:0] b;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("'");
		send_text("''");
		send_text("<=>=!==");
		send_text("(),*");
		send_text("-9Z_. -!x>");
		send_byte(CH_QUOTE, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);

		while (sent < TEXT_BYTES) begin
			query_bytes.delete();
			frags = $urandom_range(1, 8);
			for (int f = 0; f < frags; f++) begin
				choice = $urandom_range(0, 9);
				case (choice)
					0, 1, 9: begin
						len = $urandom_range(1, 6);
						repeat (len) add_byte(pick(
							"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_."));
					end
					2: begin
						if ($urandom_range(0, 1))
							add_byte(CH_MINUS);
						len = $urandom_range(1, 4);
						repeat (len) add_byte(pick("0123456789"));
					end
					3: begin
						add_byte(CH_QUOTE);
						len = $urandom_range(0, 5);
						repeat (len) begin
							b = $urandom_range(0, 1) ? pick("ab Z9_-=<('") :
								8'($urandom_range(0, 255));
							add_byte((b == CH_QUOTE) ? 8'h20 : b);
						end
						if ($urandom_range(0, 5) != 0)
							add_byte(CH_QUOTE);
					end
					4: begin
						case ($urandom_range(0, 5))
							0: push_str(">=");
							1: push_str("<=");
							2: push_str("!=");
							3: push_str("=");
							4: push_str("<");
							default: push_str(">");
						endcase
					end
					5: add_byte(pick("(),*"));
					6: add_byte(8'h20);
					7: add_byte(8'($urandom_range(0, 255)));
					default: add_byte(pick("-!"));
				endcase
				if ($urandom_range(0, 9) < 6)
					add_byte(8'h20);
			end
			foreach (query_bytes[i])
				send_byte(query_bytes[i], i == query_bytes.size() - 1);
		end
		s_tvalid <= 1'b0;

		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[query_text_lexer_core] OK");
		else
			$display("[query_text_lexer_core] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
rtl/core/qtl_pkg.sv
rtl/core/query_text_lexer_core.sv
verif/query_text_lexer_checker.sv
verif/query_text_lexer_core_test.sv
